FILE: rtl/dsvf_pkg.sv
`default_nettype none

package dsvf_pkg;

    // Default widths
    localparam int SAMPLE_BITS_DEF    = 24;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // Configuration register indexes
    localparam int CFG_ADDR_BITS = 3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FREQ1 = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DAMP1 = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FREQ2 = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_DAMP2 = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MODE1 = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MODE2 = 3'd5;

    // Filter tap modes
    localparam int MODE_BITS = 3;
    localparam logic [MODE_BITS-1:0] MODE_LOW   = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_HIGH  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_NOTCH = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_BAND  = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_PEAK  = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_OFF   = 3'd5;

    // Datapath register codes
    localparam logic [3:0] REG_X    = 4'd0;
    localparam logic [3:0] REG_MEAN = 4'd1;
    localparam logic [3:0] REG_L1   = 4'd2;
    localparam logic [3:0] REG_B1   = 4'd3;
    localparam logic [3:0] REG_N1   = 4'd4;
    localparam logic [3:0] REG_H1   = 4'd5;
    localparam logic [3:0] REG_L2   = 4'd6;
    localparam logic [3:0] REG_B2   = 4'd7;
    localparam logic [3:0] REG_N2   = 4'd8;
    localparam logic [3:0] REG_H2   = 4'd9;
    localparam logic [3:0] REG_V    = 4'd10;

    // Coefficient select codes
    localparam logic [1:0] COEF_F1 = 2'd0;
    localparam logic [1:0] COEF_D1 = 2'd1;
    localparam logic [1:0] COEF_F2 = 2'd2;
    localparam logic [1:0] COEF_D2 = 2'd3;

    // ALU operations
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_TAP1  = 2'd2;
    localparam logic [1:0] OP_FINAL = 2'd3;

    // Phases of one filter half-step
    localparam logic [2:0] PH_DAMP_MUL = 3'd0;
    localparam logic [2:0] PH_NOTCH    = 3'd1;
    localparam logic [2:0] PH_LOW      = 3'd2;
    localparam logic [2:0] PH_HIGH     = 3'd3;
    localparam logic [2:0] PH_BAND_MUL = 3'd4;
    localparam logic [2:0] PH_BAND     = 3'd5;

    // Program layout
    localparam int STEP_BITS = 5;
    localparam logic [STEP_BITS-1:0] STEP_TAP1A = 5'd6;
    localparam logic [STEP_BITS-1:0] STEP_S2A   = 5'd7;
    localparam logic [STEP_BITS-1:0] STEP_S1B   = 5'd13;
    localparam logic [STEP_BITS-1:0] STEP_TAP1B = 5'd19;
    localparam logic [STEP_BITS-1:0] STEP_S2B   = 5'd20;
    localparam logic [STEP_BITS-1:0] STEP_FINAL = 5'd26;

    // One control word
    typedef struct packed {
        logic                 mul_en;
        logic [1:0]           mul_coef;
        logic [3:0]           mul_src;
        logic [1:0]           alu_op;
        logic [3:0]           alu_dst;
        logic [3:0]           alu_a;
        logic                 alu_b_prod;
        logic                 alu_b_neg;
        logic [3:0]           alu_b;
        logic                 jmp_off;
        logic [STEP_BITS-1:0] jmp_tgt;
        logic                 last;
    } t_uword;

    // Sequencer to datapath
    typedef struct packed {
        logic   load;
        logic   exec;
        t_uword uw;
    } t_seq_cmd;

    // Control word for one phase of a half-step
    function automatic t_uword dsvf_half(input logic [2:0] ph, input logic st2,
                                         input logic [3:0] src);
        t_uword     w;
        logic [3:0] lo;
        logic [3:0] bd;
        logic [3:0] nt;
        logic [3:0] hi;
        logic [1:0] cfq;
        logic [1:0] cdp;
        w   = '0;
        lo  = st2 ? REG_L2 : REG_L1;
        bd  = st2 ? REG_B2 : REG_B1;
        nt  = st2 ? REG_N2 : REG_N1;
        hi  = st2 ? REG_H2 : REG_H1;
        cfq = st2 ? COEF_F2 : COEF_F1;
        cdp = st2 ? COEF_D2 : COEF_D1;
        case (ph)
            PH_DAMP_MUL: begin
                w.mul_en   = 1'b1;
                w.mul_coef = cdp;
                w.mul_src  = bd;
            end
            PH_NOTCH: begin
                w.alu_op     = OP_ADD;
                w.alu_dst    = nt;
                w.alu_a      = src;
                w.alu_b_prod = 1'b1;
                w.alu_b_neg  = 1'b1;
                w.mul_en     = 1'b1;
                w.mul_coef   = cfq;
                w.mul_src    = bd;
            end
            PH_LOW: begin
                w.alu_op     = OP_ADD;
                w.alu_dst    = lo;
                w.alu_a      = lo;
                w.alu_b_prod = 1'b1;
            end
            PH_HIGH: begin
                w.alu_op    = OP_ADD;
                w.alu_dst   = hi;
                w.alu_a     = nt;
                w.alu_b     = lo;
                w.alu_b_neg = 1'b1;
            end
            PH_BAND_MUL: begin
                w.mul_en   = 1'b1;
                w.mul_coef = cfq;
                w.mul_src  = hi;
            end
            PH_BAND: begin
                w.alu_op     = OP_ADD;
                w.alu_dst    = bd;
                w.alu_a      = bd;
                w.alu_b_prod = 1'b1;
            end
            default: ;
        endcase
        return w;
    endfunction

    // Microprogram ROM
    function automatic t_uword dsvf_ucode(input logic [STEP_BITS-1:0] step);
        t_uword w;
        w = '0;
        priority if (step < STEP_TAP1A) begin
            w = dsvf_half(step[2:0], 1'b0, REG_MEAN);
        end else if (step == STEP_TAP1A) begin
            w.alu_op  = OP_TAP1;
            w.alu_dst = REG_V;
            w.alu_a   = REG_MEAN;
            w.alu_b   = REG_B1;
            w.jmp_off = 1'b1;
            w.jmp_tgt = STEP_S1B;
        end else if (step < STEP_S1B) begin
            w = dsvf_half(3'(step - STEP_S2A), 1'b1, REG_V);
        end else if (step < STEP_TAP1B) begin
            w = dsvf_half(3'(step - STEP_S1B), 1'b0, REG_X);
        end else if (step == STEP_TAP1B) begin
            w.alu_op  = OP_TAP1;
            w.alu_dst = REG_V;
            w.alu_a   = REG_X;
            w.alu_b   = REG_B1;
            w.jmp_off = 1'b1;
            w.jmp_tgt = STEP_FINAL;
        end else if (step < STEP_FINAL) begin
            w = dsvf_half(3'(step - STEP_S2B), 1'b1, REG_V);
        end else if (step == STEP_FINAL) begin
            w.alu_op = OP_FINAL;
            w.alu_a  = REG_V;
            w.alu_b  = REG_B2;
            w.last   = 1'b1;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/dsvf_seq.sv
`default_nettype none

module dsvf_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    input  wire logic               i_stage2_off,
    output dsvf_pkg::t_seq_cmd      o_cmd
);

    logic                           r_busy;
    logic                           n_busy;
    logic [dsvf_pkg::STEP_BITS-1:0] r_step;
    logic [dsvf_pkg::STEP_BITS-1:0] n_step;
    logic                           r_out_valid;
    logic                           n_out_valid;
    dsvf_pkg::t_uword               uw;
    logic                           hold;
    logic                           exec;
    logic                           load;

    // Control word fetch; last step waits for a free output register
    always_comb begin
        uw   = dsvf_pkg::dsvf_ucode(r_step);
        hold = uw.last && r_out_valid && i_out_stall;
        exec = r_busy && !hold;
        load = i_in_valid && !r_busy;
    end

    // Step counter with conditional jump
    always_comb begin
        n_busy = r_busy;
        n_step = r_step;
        if (load) begin
            n_busy = 1'b1;
            n_step = '0;
        end else if (exec) begin
            if (uw.last) begin
                n_busy = 1'b0;
            end else if (uw.jmp_off && i_stage2_off) begin
                n_step = uw.jmp_tgt;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    // Output word valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (exec && uw.last) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_busy;
    assign o_out_valid = r_out_valid;
    assign o_cmd.load  = load;
    assign o_cmd.exec  = exec;
    assign o_cmd.uw    = uw;

endmodule

`default_nettype wire

FILE: rtl/dsvf_dp.sv
`default_nettype none

module dsvf_dp #(
    parameter int SAMPLE_BITS    = dsvf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = dsvf_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire dsvf_pkg::t_seq_cmd                  i_cmd,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_sample_in,
    input  wire logic [COEF_FRAC_BITS+1:0]           i_freq1,
    input  wire logic [COEF_FRAC_BITS+1:0]           i_damp1,
    input  wire logic [COEF_FRAC_BITS+1:0]           i_freq2,
    input  wire logic [COEF_FRAC_BITS+1:0]           i_damp2,
    input  wire logic [dsvf_pkg::MODE_BITS-1:0]      i_mode1,
    input  wire logic [dsvf_pkg::MODE_BITS-1:0]      i_mode2,
    output logic signed [SAMPLE_BITS-1:0]            o_sample_out
);

    localparam int SW  = SAMPLE_BITS + 8;          // state width, Q8.x
    localparam int EXT = SW - SAMPLE_BITS;
    localparam int CW  = COEF_FRAC_BITS + 2;
    localparam int PW  = CW + 1 + SW;              // product width
    localparam int RW  = PW + 1 - COEF_FRAC_BITS;  // rounded product width
    localparam int AW  = SW + 5;                   // adder width
    localparam logic [PW:0] ROUND_ONE =
        {{(PW + 1 - COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};

    // Saturate an adder result to the state range
    function automatic logic signed [SW-1:0] sat_state(input logic signed [AW-1:0] v);
        logic [AW-SW:0] top;
        top = v[AW-1:SW-1];
        if (&top || !(|top)) begin
            return v[SW-1:0];
        end
        return v[AW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    endfunction

    // State and scratch registers
    logic signed [SW-1:0]          r_x;
    logic signed [SW-1:0]          r_mean;
    logic signed [SW-1:0]          r_l1;
    logic signed [SW-1:0]          r_b1;
    logic signed [SW-1:0]          r_n1;
    logic signed [SW-1:0]          r_h1;
    logic signed [SW-1:0]          r_l2;
    logic signed [SW-1:0]          r_b2;
    logic signed [SW-1:0]          r_n2;
    logic signed [SW-1:0]          r_h2;
    logic signed [SW-1:0]          r_v;
    logic signed [PW-1:0]          r_prod;
    logic signed [SAMPLE_BITS-1:0] r_sample_out;

    logic signed [SAMPLE_BITS:0]   mean_sum;
    logic signed [SW-1:0]          x_ext;
    logic signed [SW-1:0]          mean_ext;
    logic signed [SW-1:0]          a_val;
    logic signed [SW-1:0]          b_val;
    logic signed [SW-1:0]          m_val;
    logic [CW-1:0]                 coef;
    logic signed [CW:0]            mul_a;
    logic signed [PW:0]            rnd_sum;
    logic signed [RW-1:0]          prod_rnd;
    logic signed [AW-1:0]          a_ext;
    logic signed [AW-1:0]          b_ext;
    logic signed [AW-1:0]          b_opr;
    logic signed [AW-1:0]          add_sum;
    logic signed [SW-1:0]          add_sat;
    logic signed [SW-1:0]          tap1;
    logic signed [SW-1:0]          peak2;
    logic signed [SW-1:0]          fin;
    logic signed [SW-1:0]          alu_res;
    logic [EXT:0]                  fin_top;
    logic signed [SAMPLE_BITS-1:0] fin_clamp;
    logic                          wr;

    // Incoming word and the mean with the previous one (floor)
    always_comb begin
        mean_sum = {r_x[SAMPLE_BITS-1], r_x[SAMPLE_BITS-1:0]}
                 + {i_sample_in[SAMPLE_BITS-1], i_sample_in};
        x_ext    = {{EXT{i_sample_in[SAMPLE_BITS-1]}}, i_sample_in};
        mean_ext = {{EXT{mean_sum[SAMPLE_BITS]}}, mean_sum[SAMPLE_BITS:1]};
    end

    // Operand A select
    always_comb begin
        unique case (i_cmd.uw.alu_a)
            dsvf_pkg::REG_X:    a_val = r_x;
            dsvf_pkg::REG_MEAN: a_val = r_mean;
            dsvf_pkg::REG_L1:   a_val = r_l1;
            dsvf_pkg::REG_B1:   a_val = r_b1;
            dsvf_pkg::REG_N1:   a_val = r_n1;
            dsvf_pkg::REG_H1:   a_val = r_h1;
            dsvf_pkg::REG_L2:   a_val = r_l2;
            dsvf_pkg::REG_B2:   a_val = r_b2;
            dsvf_pkg::REG_N2:   a_val = r_n2;
            dsvf_pkg::REG_H2:   a_val = r_h2;
            dsvf_pkg::REG_V:    a_val = r_v;
            default:            a_val = '0;
        endcase
    end

    // Operand B select
    always_comb begin
        unique case (i_cmd.uw.alu_b)
            dsvf_pkg::REG_X:    b_val = r_x;
            dsvf_pkg::REG_MEAN: b_val = r_mean;
            dsvf_pkg::REG_L1:   b_val = r_l1;
            dsvf_pkg::REG_B1:   b_val = r_b1;
            dsvf_pkg::REG_N1:   b_val = r_n1;
            dsvf_pkg::REG_H1:   b_val = r_h1;
            dsvf_pkg::REG_L2:   b_val = r_l2;
            dsvf_pkg::REG_B2:   b_val = r_b2;
            dsvf_pkg::REG_N2:   b_val = r_n2;
            dsvf_pkg::REG_H2:   b_val = r_h2;
            dsvf_pkg::REG_V:    b_val = r_v;
            default:            b_val = '0;
        endcase
    end

    // Multiplier operand select
    always_comb begin
        unique case (i_cmd.uw.mul_src)
            dsvf_pkg::REG_B1: m_val = r_b1;
            dsvf_pkg::REG_H1: m_val = r_h1;
            dsvf_pkg::REG_B2: m_val = r_b2;
            dsvf_pkg::REG_H2: m_val = r_h2;
            default:          m_val = '0;
        endcase
        unique case (i_cmd.uw.mul_coef)
            dsvf_pkg::COEF_F1: coef = i_freq1;
            dsvf_pkg::COEF_D1: coef = i_damp1;
            dsvf_pkg::COEF_F2: coef = i_freq2;
            dsvf_pkg::COEF_D2: coef = i_damp2;
        endcase
        mul_a = {1'b0, coef};
    end

    // Round the product to the state scale, then add or subtract
    always_comb begin
        rnd_sum  = {r_prod[PW-1], r_prod} + ROUND_ONE;
        prod_rnd = rnd_sum[PW:COEF_FRAC_BITS];
        a_ext    = {{(AW-SW){a_val[SW-1]}}, a_val};
        b_ext    = i_cmd.uw.alu_b_prod ? {{(AW-RW){prod_rnd[RW-1]}}, prod_rnd}
                                       : {{(AW-SW){b_val[SW-1]}}, b_val};
        b_opr    = i_cmd.uw.alu_b_neg ? -b_ext : b_ext;
        add_sum  = a_ext + b_opr;
        add_sat  = sat_state(add_sum);
    end

    // Stage one tap; peak is input plus band
    always_comb begin
        unique case (i_mode1)
            dsvf_pkg::MODE_HIGH:  tap1 = r_h1;
            dsvf_pkg::MODE_NOTCH: tap1 = r_n1;
            dsvf_pkg::MODE_BAND:  tap1 = r_b1;
            dsvf_pkg::MODE_PEAK:  tap1 = add_sat;
            default:              tap1 = r_l1;
        endcase
    end

    // Result tap; stage two off passes stage one through
    always_comb begin
        peak2 = (i_mode1 == dsvf_pkg::MODE_PEAK) ? {add_sat[SW-1], add_sat[SW-1:1]}
                                                  : add_sat;
        unique case (i_mode2)
            dsvf_pkg::MODE_LOW:   fin = r_l2;
            dsvf_pkg::MODE_HIGH:  fin = r_h2;
            dsvf_pkg::MODE_NOTCH: fin = r_n2;
            dsvf_pkg::MODE_BAND:  fin = r_b2;
            dsvf_pkg::MODE_PEAK:  fin = peak2;
            default:              fin = r_v;
        endcase
        fin_top = fin[SW-1:SAMPLE_BITS-1];
        if (&fin_top || !(|fin_top)) begin
            fin_clamp = fin[SAMPLE_BITS-1:0];
        end else begin
            fin_clamp = fin[SW-1] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                  : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    always_comb begin
        unique case (i_cmd.uw.alu_op)
            dsvf_pkg::OP_ADD:  alu_res = add_sat;
            dsvf_pkg::OP_TAP1: alu_res = tap1;
            default:           alu_res = '0;
        endcase
        wr = i_cmd.exec && ((i_cmd.uw.alu_op == dsvf_pkg::OP_ADD)
                         || (i_cmd.uw.alu_op == dsvf_pkg::OP_TAP1));
    end

    // Filter state, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x  <= '0;
            r_l1 <= '0;
            r_b1 <= '0;
            r_l2 <= '0;
            r_b2 <= '0;
        end else begin
            if (i_cmd.load) begin
                r_x <= x_ext;
            end
            if (wr) begin
                unique case (i_cmd.uw.alu_dst)
                    dsvf_pkg::REG_L1: r_l1 <= alu_res;
                    dsvf_pkg::REG_B1: r_b1 <= alu_res;
                    dsvf_pkg::REG_L2: r_l2 <= alu_res;
                    dsvf_pkg::REG_B2: r_b2 <= alu_res;
                    default: ;
                endcase
            end
        end
    end

    // Scratch registers, product and output word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mean <= mean_ext;
        end
        if (i_cmd.exec && i_cmd.uw.mul_en) begin
            r_prod <= mul_a * m_val;
        end
        if (wr) begin
            unique case (i_cmd.uw.alu_dst)
                dsvf_pkg::REG_N1: r_n1 <= alu_res;
                dsvf_pkg::REG_H1: r_h1 <= alu_res;
                dsvf_pkg::REG_N2: r_n2 <= alu_res;
                dsvf_pkg::REG_H2: r_h2 <= alu_res;
                dsvf_pkg::REG_V:  r_v  <= alu_res;
                default: ;
            endcase
        end
        if (i_cmd.exec && i_cmd.uw.alu_op == dsvf_pkg::OP_FINAL) begin
            r_sample_out <= fin_clamp;
        end
    end

    assign o_sample_out = r_sample_out;

endmodule

`default_nettype wire

FILE: rtl/dual_state_variable_filter.sv
`default_nettype none

// Two cascaded Chamberlin state variable filters, each run twice per sample
// (first half-step on the mean of the previous and current sample, second on
// the current sample). Samples are signed Q0.(SAMPLE_BITS-1), coefficients
// unsigned Q2.COEF_FRAC_BITS, and state saturates in Q8.(SAMPLE_BITS-1). One
// shared multiplier and one adder are driven by a 27-step microprogram; each
// half-step takes six steps because its three multiplies and four saturating
// adds go through that single multiplier and adder in turn. The result word of
// a sample is written by the final step; with stage two off, the program jumps
// over the stage-two steps. The next sample can be accepted as soon as the word
// is valid. The input is stalled while a sample is in work; a finished word
// waits in the output register and the next sample may be accepted meanwhile,
// but its final step waits until that word has been taken. Configuration is
// written through i_cfg_we/i_cfg_addr/i_cfg_data while the block is idle; the
// user must keep to this, as the block does not enforce it. Unknown indexes
// are ignored.
module dual_state_variable_filter #(
    parameter int SAMPLE_BITS    = dsvf_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_FRAC_BITS = dsvf_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_we,
    input  wire logic [dsvf_pkg::CFG_ADDR_BITS-1:0]    i_cfg_addr,
    input  wire logic [COEF_FRAC_BITS+1:0]             i_cfg_data,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]         i_sample_in,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]              o_sample_out
);

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam logic [CW-1:0] DAMP_RESET = {2'b10, {COEF_FRAC_BITS{1'b0}}};

    logic [CW-1:0]                  r_freq1;
    logic [CW-1:0]                  r_damp1;
    logic [CW-1:0]                  r_freq2;
    logic [CW-1:0]                  r_damp2;
    logic [dsvf_pkg::MODE_BITS-1:0] r_mode1;
    logic [dsvf_pkg::MODE_BITS-1:0] r_mode2;
    logic                           stage2_off;
    dsvf_pkg::t_seq_cmd             cmd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq1 <= '0;
            r_damp1 <= DAMP_RESET;
            r_freq2 <= '0;
            r_damp2 <= DAMP_RESET;
            r_mode1 <= dsvf_pkg::MODE_LOW;
            r_mode2 <= dsvf_pkg::MODE_OFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                dsvf_pkg::CFG_FREQ1: r_freq1 <= i_cfg_data;
                dsvf_pkg::CFG_DAMP1: r_damp1 <= i_cfg_data;
                dsvf_pkg::CFG_FREQ2: r_freq2 <= i_cfg_data;
                dsvf_pkg::CFG_DAMP2: r_damp2 <= i_cfg_data;
                dsvf_pkg::CFG_MODE1: r_mode1 <= i_cfg_data[dsvf_pkg::MODE_BITS-1:0];
                dsvf_pkg::CFG_MODE2: r_mode2 <= i_cfg_data[dsvf_pkg::MODE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Any mode code from off upward bypasses stage two
    assign stage2_off = (r_mode2 >= dsvf_pkg::MODE_OFF);

    dsvf_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_stage2_off (stage2_off),
        .o_cmd        (cmd)
    );

    dsvf_dp #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_sample_in  (i_sample_in),
        .i_freq1      (r_freq1),
        .i_damp1      (r_damp1),
        .i_freq2      (r_freq2),
        .i_damp2      (r_damp2),
        .i_mode1      (r_mode1),
        .i_mode2      (r_mode2),
        .o_sample_out (o_sample_out)
    );

    // One sample in work at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a sample is in work");

    // The output register is never overwritten while a word waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.exec && cmd.uw.last) |-> (!o_out_valid || !i_out_stall))
        else $error("output word overwritten");

    // A result appears only after the final program step
    a_valid_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.exec && cmd.uw.last))
        else $error("output valid without final step");

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int SW     = dsvf_pkg::SAMPLE_BITS_DEF;
    localparam int CW     = dsvf_pkg::COEF_FRAC_BITS_DEF + 2;
    localparam int FRAC   = dsvf_pkg::COEF_FRAC_BITS_DEF;
    localparam int MODE_W = dsvf_pkg::MODE_BITS;
    localparam int ADDR_W = dsvf_pkg::CFG_ADDR_BITS;

    localparam longint ST_HI  = (64'sd1 <<< (SW + 7)) - 1;
    localparam longint ST_LO  = -ST_HI - 1;
    localparam longint SMP_HI = (64'sd1 <<< (SW - 1)) - 1;
    localparam longint SMP_LO = -SMP_HI - 1;

    // indexes and tap codes the package leaves unnamed
    localparam logic [ADDR_W-1:0] CFG_SPARE6 = 3'd6;
    localparam logic [ADDR_W-1:0] CFG_SPARE7 = 3'd7;
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

    localparam int RAND_PHASES = 9;
    localparam int PHASE_WORDS = 72;
    localparam int LONG_HOLD   = 300;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [ADDR_W-1:0]            i_cfg_addr;
    logic [CW-1:0]                i_cfg_data;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic signed [SW-1:0]         i_sample_in;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic signed [SW-1:0]         o_sample_out;

    dual_state_variable_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_sample_in (i_sample_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_sample_out(o_sample_out)
    );

    always #2 i_clk = ~i_clk;

    // Filter state as seen by the predictor
    typedef struct {
        longint low;
        longint band;
        longint notch;
        longint high;
    } t_svf_vars;

    t_svf_vars       flt1;
    t_svf_vars       flt2;
    longint          last_x;
    logic [CW-1:0]   freq1, damp1, freq2, damp2;
    logic [MODE_W-1:0] tap1_sel, tap2_sel;

    logic signed [SW-1:0] sample_queue[$];
    logic [SW-1:0]        filtered_expect[$];
    int                   send_idle_pct;
    int                   recv_idle_pct;
    int                   fail_count;
    int                   words_seen;
    int                   hold_left;
    bit                   hold_done;

    function automatic longint clamp_state(longint v);
        if (v > ST_HI) return ST_HI;
        if (v < ST_LO) return ST_LO;
        return v;
    endfunction

    // coef * v rounded back to v's scale, floor shift
    function automatic longint coef_mul(logic [CW-1:0] c, longint v);
        longint cl;
        longint p;
        cl = c;
        p = cl * v + (64'sd1 <<< (FRAC - 1));
        return p >>> FRAC;
    endfunction

    function automatic t_svf_vars svf_half(t_svf_vars s, longint x,
                                           logic [CW-1:0] f, logic [CW-1:0] d);
        t_svf_vars n;
        n = s;
        n.notch = clamp_state(x - coef_mul(d, s.band));
        n.low   = clamp_state(s.low + coef_mul(f, s.band));
        n.high  = clamp_state(n.notch - n.low);
        n.band  = clamp_state(s.band + coef_mul(f, n.high));
        return n;
    endfunction

    function automatic longint stage1_out(longint x);
        case (tap1_sel)
            dsvf_pkg::MODE_HIGH:  return flt1.high;
            dsvf_pkg::MODE_NOTCH: return flt1.notch;
            dsvf_pkg::MODE_BAND:  return flt1.band;
            dsvf_pkg::MODE_PEAK:  return clamp_state(x + flt1.band);
            default:              return flt1.low;
        endcase
    endfunction

    // Advance the predictor by one input word, return the filtered word
    function automatic logic [SW-1:0] filter_sample(logic signed [SW-1:0] s);
        longint x;
        longint mean;
        longint v;
        longint r;
        bit     on;
        x = s;
        mean = (last_x + x) >>> 1;
        last_x = x;
        on = tap2_sel < dsvf_pkg::MODE_OFF;
        flt1 = svf_half(flt1, mean, freq1, damp1);
        if (on) flt2 = svf_half(flt2, stage1_out(mean), freq2, damp2);
        flt1 = svf_half(flt1, x, freq1, damp1);
        v = stage1_out(x);
        if (!on) begin
            r = v;
        end else begin
            flt2 = svf_half(flt2, v, freq2, damp2);
            case (tap2_sel)
                dsvf_pkg::MODE_LOW:   r = flt2.low;
                dsvf_pkg::MODE_HIGH:  r = flt2.high;
                dsvf_pkg::MODE_NOTCH: r = flt2.notch;
                dsvf_pkg::MODE_BAND:  r = flt2.band;
                default: begin
                    r = clamp_state(v + flt2.band);
                    if (tap1_sel == dsvf_pkg::MODE_PEAK) r = r >>> 1;
                end
            endcase
        end
        if (r > SMP_HI) r = SMP_HI;
        if (r < SMP_LO) r = SMP_LO;
        return r[SW-1:0];
    endfunction

    // Sender: feeds words from the queue, holds them while stalled
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                filtered_expect.push_back(filter_sample(i_sample_in));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid  <= 1'b1;
                    i_sample_in <= sample_queue.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each word, stalls at random, once for a long stretch
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                words_seen++;
                if (filtered_expect.size() == 0) begin
                    $display("%0t: unexpected word, got %0d", $time, o_sample_out);
                    fail_count++;
                end else begin
                    logic [SW-1:0] want;
                    want = filtered_expect.pop_front();
                    if (o_sample_out !== want) begin
                        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                                 $time, $signed(want), o_sample_out);
                        fail_count++;
                    end
                end
            end
            if (words_seen == 40 && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Register write; the predictor's copy follows the same decode
    task automatic cfg_write(input logic [ADDR_W-1:0] idx, input logic [CW-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            dsvf_pkg::CFG_FREQ1: freq1 = val;
            dsvf_pkg::CFG_DAMP1: damp1 = val;
            dsvf_pkg::CFG_FREQ2: freq2 = val;
            dsvf_pkg::CFG_DAMP2: damp2 = val;
            dsvf_pkg::CFG_MODE1: tap1_sel = val[MODE_W-1:0];
            dsvf_pkg::CFG_MODE2: tap2_sel = val[MODE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_all(input logic [CW-1:0] f1, input logic [CW-1:0] d1,
                           input logic [CW-1:0] f2, input logic [CW-1:0] d2,
                           input logic [MODE_W-1:0] m1, input logic [MODE_W-1:0] m2);
        cfg_write(dsvf_pkg::CFG_FREQ1, f1);
        cfg_write(dsvf_pkg::CFG_DAMP1, d1);
        cfg_write(dsvf_pkg::CFG_FREQ2, f2);
        cfg_write(dsvf_pkg::CFG_DAMP2, d2);
        cfg_write(dsvf_pkg::CFG_MODE1, CW'(m1));
        cfg_write(dsvf_pkg::CFG_MODE2, CW'(m2));
    endtask

    // Wait until every queued word is sent and every result is back
    task automatic drain();
        do @(posedge i_clk);
        while (sample_queue.size() != 0 || filtered_expect.size() != 0 || i_in_valid);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [CW-1:0] rand_coef();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return CW'($urandom_range(1, 20000));
            default: return CW'($urandom());
        endcase
    endfunction

    function automatic logic signed [SW-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return SMP_HI[SW-1:0];
            1:       return SMP_LO[SW-1:0];
            2, 3:    return SW'($urandom_range(0, 511)) - SW'(256);
            default: return SW'($urandom());
        endcase
    endfunction

    initial begin
        int n;
        int run;
        logic signed [SW-1:0] val;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_addr = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_sample_in = '0;
        i_out_stall = 1'b0;
        send_idle_pct = 30;
        recv_idle_pct = 60;
        fail_count = 0;
        words_seen = 0;
        hold_left = 0;
        hold_done = 1'b0;
        flt1 = '{0, 0, 0, 0};
        flt2 = '{0, 0, 0, 0};
        last_x = 0;
        freq1 = '0;
        damp1 = CW'(2 << FRAC);
        freq2 = '0;
        damp2 = CW'(2 << FRAC);
        tap1_sel = dsvf_pkg::MODE_LOW;
        tap2_sel = dsvf_pkg::MODE_OFF;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, sample extremes
        @(negedge i_clk);
        sample_queue.push_back(SMP_HI[SW-1:0]);
        sample_queue.push_back(SMP_LO[SW-1:0]);
        sample_queue.push_back('0);
        sample_queue.push_back('1);
        sample_queue.push_back(SW'(1));
        drain();

        // max freqs, damping 0 in one and max in two, peak in both; spare indexes ignored
        set_all('1, '0, '1, '1, dsvf_pkg::MODE_PEAK, dsvf_pkg::MODE_PEAK);
        cfg_write(CFG_SPARE6, CW'($urandom()));
        cfg_write(CFG_SPARE7, CW'($urandom()));
        @(negedge i_clk);
        sample_queue.push_back(SMP_HI[SW-1:0]);
        sample_queue.push_back(SMP_HI[SW-1:0]);
        sample_queue.push_back(SMP_LO[SW-1:0]);
        sample_queue.push_back(SMP_LO[SW-1:0]);
        sample_queue.push_back('0);
        drain();

        // unused tap codes: stage one falls back to low, stage two to off
        set_all(CW'(16'h2000), CW'(17'h10000), CW'(16'h3000), CW'(16'h8000),
                MODE_SPARE7, MODE_SPARE6);
        @(negedge i_clk);
        for (int i = 0; i < 4; i++) sample_queue.push_back(rand_sample());
        drain();
        cfg_write(dsvf_pkg::CFG_MODE1, CW'(dsvf_pkg::MODE_OFF));
        cfg_write(dsvf_pkg::CFG_MODE2, CW'(MODE_SPARE7));

        // every tap of each stage
        for (int k = 0; k < 5; k++) begin
            cfg_write(dsvf_pkg::CFG_MODE1, CW'(k));
            cfg_write(dsvf_pkg::CFG_MODE2, CW'((k + 1) % 5));
            @(negedge i_clk);
            sample_queue.push_back(SMP_HI[SW-1:0] >>> 1);
            sample_queue.push_back(rand_sample());
            drain();
        end

        // random settings and random sample runs
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < 3) begin
                send_idle_pct = 30;
                recv_idle_pct = 60;
            end else if (p < 6) begin
                send_idle_pct = 60;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_all(rand_coef(), rand_coef(), rand_coef(), rand_coef(),
                    MODE_W'($urandom_range(0, 7)), MODE_W'($urandom_range(0, 7)));
            if ($urandom_range(0, 3) == 0) cfg_write(CFG_SPARE6, CW'($urandom()));
            @(negedge i_clk);
            n = 0;
            while (n < PHASE_WORDS) begin
                case ($urandom_range(0, 3))
                    // held level: lets the filters settle
                    0: begin
                        run = $urandom_range(8, 30);
                        val = rand_sample();
                        for (int i = 0; i < run; i++) sample_queue.push_back(val);
                    end
                    // square wave around zero
                    1: begin
                        run = $urandom_range(8, 30);
                        val = rand_sample();
                        for (int i = 0; i < run; i++)
                            sample_queue.push_back(((i / 4) % 2) ? -val : val);
                    end
                    default: begin
                        run = 1;
                        sample_queue.push_back(rand_sample());
                    end
                endcase
                n += run;
            end
            drain();
        end

        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/dsvf_pkg.sv
rtl/dsvf_seq.sv
rtl/dsvf_dp.sv
rtl/dual_state_variable_filter.sv
test/testbench.sv
